/* rtl/sism_pkg.sv */
// Shared types and constants of the sorted identifier set.
// No dependencies; every other file refers to it by scoped names.
package sism_pkg;

    localparam int SET_DEPTH   = 256;
    localparam int ID_WIDTH    = 32;
    localparam int FIELD_W     = 32;
    localparam int MODE_W      = 2;
    localparam int COUNT_OUT_W = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    // Controller to datapath: one strobe per step of the sequencer.
    typedef struct packed {
        logic capture;
        logic exec;
        logic sort_key_rd;
        logic sort_key;
        logic sort_cmp;
        logic sort_put;
        logic q_probe;
        logic q_cmp;
        logic q_chk1;
        logic q_chk2;
        logic out_load;
    } cmd_t;

    // Datapath to controller: branch conditions.
    typedef struct packed {
        mode_t mode;
        logic  sort_needed;
        logic  sort_gt;
        logic  j_is_one;
        logic  sort_more;
        logic  probe_go;
        logic  probe_chk;
        logic  chk_hit;
        logic  chk_more;
        logic  out_free;
    } status_t;

endpackage

/* rtl/sism_if.sv */
// Valid/ready channels for items and results of the identifier set.
// Depends on sism_pkg for the field widths.
interface sism_item_if;
    logic                              valid;
    logic                              ready;
    logic [sism_pkg::MODE_W-1:0]       mode;
    logic [sism_pkg::FIELD_W-1:0]      ident;
    logic                              last;

    modport source (output valid, mode, ident, last, input ready);
    modport sink   (input valid, mode, ident, last, output ready);
endinterface

interface sism_result_if;
    logic                              valid;
    logic                              ready;
    logic                              present;
    logic                              duplicated;
    logic                              accepted;
    logic                              overflow;
    logic [sism_pkg::COUNT_OUT_W-1:0]  entry_count;

    modport source (output valid, present, duplicated, accepted, overflow, entry_count,
                    input ready);
    modport sink   (input valid, present, duplicated, accepted, overflow, entry_count,
                    output ready);
endinterface

/* rtl/sism_controller.sv */
// Sequencer of the identifier set: clear, append, insertion sort, binary search.
// Depends on sism_pkg for the command and status structs.
module sism_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sism_pkg::status_t st,
    output sism_pkg::cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_EXEC     = 11'b000_0000_0010,
        S_SORT_RD  = 11'b000_0000_0100,
        S_SORT_KEY = 11'b000_0000_1000,
        S_SORT_CMP = 11'b000_0001_0000,
        S_SORT_PUT = 11'b000_0010_0000,
        S_Q_PROBE  = 11'b000_0100_0000,
        S_Q_CMP    = 11'b000_1000_0000,
        S_Q_CHK1   = 11'b001_0000_0000,
        S_Q_CHK2   = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (st.mode)
                    sism_pkg::MODE_APPEND: state_next = st.sort_needed ? S_SORT_RD : S_DONE;
                    sism_pkg::MODE_QUERY:  state_next = S_Q_PROBE;
                    default:               state_next = S_DONE;
                endcase
            end
            S_SORT_RD:
            begin
                cmd.sort_key_rd = 1'b1;
                state_next      = S_SORT_KEY;
            end
            S_SORT_KEY:
            begin
                cmd.sort_key = 1'b1;
                state_next   = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                cmd.sort_cmp = 1'b1;
                if (st.sort_gt)
                begin
                    state_next = st.j_is_one ? S_SORT_PUT : S_SORT_CMP;
                end
                else
                begin
                    state_next = st.sort_more ? S_SORT_RD : S_DONE;
                end
            end
            S_SORT_PUT:
            begin
                cmd.sort_put = 1'b1;
                state_next   = st.sort_more ? S_SORT_RD : S_DONE;
            end
            S_Q_PROBE:
            begin
                cmd.q_probe = 1'b1;
                if (st.probe_go)
                begin
                    state_next = S_Q_CMP;
                end
                else
                begin
                    state_next = st.probe_chk ? S_Q_CHK1 : S_DONE;
                end
            end
            S_Q_CMP:
            begin
                cmd.q_cmp  = 1'b1;
                state_next = S_Q_PROBE;
            end
            S_Q_CHK1:
            begin
                cmd.q_chk1 = 1'b1;
                state_next = (st.chk_hit && st.chk_more) ? S_Q_CHK2 : S_DONE;
            end
            S_Q_CHK2:
            begin
                cmd.q_chk2 = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.out_load = st.out_free;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sism_datapath.sv */
// Datapath of the identifier set: store memory, count, sort and search registers,
// value limit register and result register. Depends on sism_pkg.
module sism_datapath #(
    parameter int SET_DEPTH = sism_pkg::SET_DEPTH,
    parameter int ID_WIDTH  = sism_pkg::ID_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [sism_pkg::FIELD_W-1:0]      cfg_wr_data,
    input  logic [sism_pkg::MODE_W-1:0]       in_mode,
    input  logic [sism_pkg::FIELD_W-1:0]      in_ident,
    input  logic                              in_last,
    input  sism_pkg::cmd_t                    cmd,
    output sism_pkg::status_t                 st,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_present,
    output logic                              out_duplicated,
    output logic                              out_accepted,
    output logic                              out_overflow,
    output logic [sism_pkg::COUNT_OUT_W-1:0]  out_entry_count
);

    localparam int IDX_W = $clog2(SET_DEPTH);
    localparam int CNT_W = $clog2(SET_DEPTH + 1);

    logic [ID_WIDTH-1:0]           mem [SET_DEPTH];
    logic [ID_WIDTH-1:0]           rdata_reg;

    logic [sism_pkg::FIELD_W-1:0]  limit_reg;
    sism_pkg::mode_t               mode_reg;
    logic [ID_WIDTH-1:0]           key_reg;
    logic                          last_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [ID_WIDTH-1:0]           sort_key_reg;
    logic [IDX_W-1:0]              i_reg;
    logic [IDX_W-1:0]              j_reg;
    logic [CNT_W-1:0]              low_reg;
    logic [CNT_W-1:0]              high_reg;
    logic [CNT_W-1:0]              mid_reg;
    logic                          present_reg;
    logic                          dup_reg;
    logic                          acc_reg;
    logic                          ovf_reg;
    logic                          out_valid_reg;
    logic                          out_present_reg;
    logic                          out_dup_reg;
    logic                          out_acc_reg;
    logic                          out_ovf_reg;
    logic [sism_pkg::COUNT_OUT_W-1:0] out_count_reg;

    logic [sism_pkg::FIELD_W-1:0]  id_ext;
    logic                          id_ok;
    logic                          full;
    logic                          do_store;
    logic [CNT_W-1:0]              count_after;
    logic [CNT_W-1:0]              mid;
    logic [CNT_W-1:0]              low_plus;
    logic [CNT_W-1:0]              i_plus;
    logic [CNT_W+sism_pkg::COUNT_OUT_W-1:0] count_wide;
    logic                          rd_lt_key;

    logic [IDX_W-1:0]              raddr;
    logic                          we;
    logic [IDX_W-1:0]              waddr;
    logic [ID_WIDTH-1:0]           wdata;

    assign id_ext      = sism_pkg::FIELD_W'(key_reg);
    assign id_ok       = (key_reg != '1) && (id_ext < limit_reg);
    assign full        = (count_reg == CNT_W'(SET_DEPTH));
    assign do_store    = id_ok && !full;
    assign count_after = do_store ? count_reg + CNT_W'(1) : count_reg;
    assign mid         = low_reg + ((high_reg - low_reg) >> 1);
    assign low_plus    = low_reg + CNT_W'(1);
    assign i_plus      = CNT_W'(i_reg) + CNT_W'(1);
    assign count_wide  = {{sism_pkg::COUNT_OUT_W{1'b0}}, count_reg};
    assign rd_lt_key   = rdata_reg < key_reg;

    assign st.mode        = mode_reg;
    assign st.sort_needed = last_reg && (count_after >= CNT_W'(2));
    assign st.sort_gt     = rdata_reg > sort_key_reg;
    assign st.j_is_one    = (j_reg == IDX_W'(1));
    assign st.sort_more   = i_plus < count_reg;
    assign st.probe_go    = low_reg < high_reg;
    assign st.probe_chk   = low_reg < count_reg;
    assign st.chk_hit     = (rdata_reg == key_reg);
    assign st.chk_more    = low_plus < count_reg;
    assign st.out_free    = !out_valid_reg || out_ready;

    // Memory address and write selection per step.
    always_comb
    begin
        raddr = '0;
        we    = 1'b0;
        waddr = count_reg[IDX_W-1:0];
        wdata = key_reg;
        if (cmd.exec && (mode_reg == sism_pkg::MODE_APPEND) && do_store)
        begin
            we = 1'b1;
        end
        if (cmd.sort_key_rd)
        begin
            raddr = i_reg;
        end
        if (cmd.sort_key)
        begin
            raddr = i_reg - IDX_W'(1);
        end
        if (cmd.sort_cmp)
        begin
            we    = 1'b1;
            waddr = j_reg;
            if (st.sort_gt)
            begin
                wdata = rdata_reg;
                raddr = j_reg - IDX_W'(2);
            end
            else
            begin
                wdata = sort_key_reg;
            end
        end
        if (cmd.sort_put)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = sort_key_reg;
        end
        if (cmd.q_probe)
        begin
            raddr = st.probe_go ? mid[IDX_W-1:0] : low_reg[IDX_W-1:0];
        end
        if (cmd.q_chk1)
        begin
            raddr = low_plus[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.exec && (mode_reg == sism_pkg::MODE_CLEAR))
            begin
                count_reg <= '0;
            end
            else if (cmd.exec && (mode_reg == sism_pkg::MODE_APPEND))
            begin
                count_reg <= count_after;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= sism_pkg::mode_t'(in_mode);
            key_reg  <= in_ident[ID_WIDTH-1:0];
            last_reg <= in_last;
        end
        if (cmd.exec)
        begin
            acc_reg     <= (mode_reg == sism_pkg::MODE_APPEND) && do_store;
            ovf_reg     <= (mode_reg == sism_pkg::MODE_APPEND) && id_ok && full;
            present_reg <= 1'b0;
            dup_reg     <= 1'b0;
            i_reg       <= IDX_W'(1);
            low_reg     <= '0;
            high_reg    <= count_reg;
        end
        if (cmd.sort_key)
        begin
            sort_key_reg <= rdata_reg;
            j_reg        <= i_reg;
        end
        if (cmd.sort_cmp)
        begin
            if (st.sort_gt)
            begin
                j_reg <= j_reg - IDX_W'(1);
            end
            else
            begin
                i_reg <= i_reg + IDX_W'(1);
            end
        end
        if (cmd.sort_put)
        begin
            i_reg <= i_reg + IDX_W'(1);
        end
        if (cmd.q_probe)
        begin
            mid_reg <= mid;
        end
        if (cmd.q_cmp)
        begin
            if (rd_lt_key)
            begin
                low_reg <= mid_reg + CNT_W'(1);
            end
            else
            begin
                high_reg <= mid_reg;
            end
        end
        if (cmd.q_chk1)
        begin
            present_reg <= st.chk_hit;
        end
        if (cmd.q_chk2)
        begin
            dup_reg <= st.chk_hit;
        end
        if (cmd.out_load)
        begin
            out_present_reg <= present_reg;
            out_dup_reg     <= dup_reg;
            out_acc_reg     <= acc_reg;
            out_ovf_reg     <= ovf_reg;
            out_count_reg   <= count_wide[sism_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_present     = out_present_reg;
    assign out_duplicated  = out_dup_reg;
    assign out_accepted    = out_acc_reg;
    assign out_overflow    = out_ovf_reg;
    assign out_entry_count = out_count_reg;

endmodule

/* rtl/sorted_id_set_membership_unit.sv */
// Top level of the sorted identifier set with lower-bound membership queries.
// Depends on sism_pkg, sism_if, sism_controller and sism_datapath.
//
//   Channel   Direction  Handshake       Payload
//   item      in         valid / ready   mode, ident, last
//   result    out        valid / ready   present, duplicated, accepted, overflow, entry_count
//   cfg       in         cfg_wr_en       cfg_wr_data (value_limit)
//
// Clear and no-op pass from the execute step straight to the result, as does an
// append; a query runs binary-search probes, each a probe and a compare step,
// then at most two check steps. An append marked last, when the store then holds two
// or more entries, adds an insertion sort over the store. Reset clears the count,
// the value limit and the result valid flag; the store needs no clearing pass.
// Input is held off (ready low) while an item works; a finished result waits in
// the output register while the next item enters.
module sorted_id_set_membership_unit #(
    parameter int SET_DEPTH = sism_pkg::SET_DEPTH,
    parameter int ID_WIDTH  = sism_pkg::ID_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sism_pkg::FIELD_W-1:0]  cfg_wr_data,
    sism_item_if.sink                     item,
    sism_result_if.source                 result
);

    sism_pkg::cmd_t    cmd;
    sism_pkg::status_t st;

    // Sequencer: accept a transaction, step through clear, append, sort or search.
    sism_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Store, indices and result register.
    sism_datapath #(
        .SET_DEPTH (SET_DEPTH),
        .ID_WIDTH  (ID_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_mode         (item.mode),
        .in_ident        (item.ident),
        .in_last         (item.last),
        .cmd             (cmd),
        .st              (st),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_present     (result.present),
        .out_duplicated  (result.duplicated),
        .out_accepted    (result.accepted),
        .out_overflow    (result.overflow),
        .out_entry_count (result.entry_count)
    );

endmodule

/* rtl/sism_checker.sv */
// Port-level checks of the identifier set, bound to the top level.
// Depends on sism_pkg and sorted_id_set_membership_unit.
module sism_checker #(
    parameter int SET_DEPTH = sism_pkg::SET_DEPTH
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic                              res_present,
    input logic                              res_duplicated,
    input logic                              res_accepted,
    input logic                              res_overflow,
    input logic [sism_pkg::COUNT_OUT_W-1:0]  res_entry_count
);

    localparam logic [sism_pkg::COUNT_OUT_W:0] DEPTH_CAP =
        (sism_pkg::COUNT_OUT_W+1)'(SET_DEPTH);

    // One item at a time: ready drops after each accepted transaction.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("input accepted twice in a row");

    // Query flags and append flags never mix.
    a_flag_groups: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !((res_present || res_duplicated) && (res_accepted || res_overflow)))
        else $error("query and append flags together");

    a_dup_needs_present: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_duplicated) |-> res_present)
        else $error("duplicated without present");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_accepted) |-> ({1'b0, res_entry_count} <= DEPTH_CAP)
            && (res_entry_count != '0))
        else $error("entry count out of range after store");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_entry_count)))
        else $error("stalled result changed");

endmodule

bind sorted_id_set_membership_unit sism_checker #(
    .SET_DEPTH (SET_DEPTH)
) u_sism_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_present     (result.present),
    .res_duplicated  (result.duplicated),
    .res_accepted    (result.accepted),
    .res_overflow    (result.overflow),
    .res_entry_count (result.entry_count)
);
